### design/tprsi_pkg.sv
`default_nettype none

package tprsi_pkg;

  localparam int PRICE_WIDTH_DEFAULT   = 24;
  localparam int FRACTION_BITS_DEFAULT = 16;
  localparam int PERIOD_WIDTH          = 8;
  localparam int RSI_WIDTH             = 14;
  localparam int NUM_PERIODS           = 3;
  localparam int ADDR_WIDTH            = 4;
  localparam int DATA_WIDTH            = 32;

  localparam logic [RSI_WIDTH-1:0]    RSI_SCALE      = 14'd10000;
  localparam logic [PERIOD_WIDTH-1:0] SHORT_DEFAULT  = 8'd6;
  localparam logic [PERIOD_WIDTH-1:0] MIDDLE_DEFAULT = 8'd12;
  localparam logic [PERIOD_WIDTH-1:0] LONG_DEFAULT   = 8'd24;

  typedef enum logic [1:0] {
    REG_SHORT  = 2'd0,
    REG_MIDDLE = 2'd1,
    REG_LONG   = 2'd2
  } tprsi_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_CHECK,
    ST_RATIO,
    ST_DONE
  } tprsi_state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic store;
  } tprsi_lane_ctrl_t;

endpackage

`default_nettype wire

### design/tprsi_smooth_lane.sv
`default_nettype none

module tprsi_smooth_lane #(
  parameter int AVG_WIDTH = tprsi_pkg::PRICE_WIDTH_DEFAULT + tprsi_pkg::FRACTION_BITS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire tprsi_pkg::tprsi_lane_ctrl_t         ctrl,
  input  wire logic [tprsi_pkg::PERIOD_WIDTH-1:0]  period,
  input  wire logic                                x_bit,
  output logic      [AVG_WIDTH-1:0]                avg
);
  import tprsi_pkg::*;

  localparam int WORK_WIDTH = AVG_WIDTH + PERIOD_WIDTH;

  logic [WORK_WIDTH-1:0]   work, work_next;
  logic [PERIOD_WIDTH-1:0] carry, carry_next;
  logic [PERIOD_WIDTH-1:0] rem, rem_next;
  logic [PERIOD_WIDTH-1:0] mult;
  logic [PERIOD_WIDTH:0]   sum;
  logic [PERIOD_WIDTH:0]   rem_sh;
  logic                    fit;

  // serial multiply-add lsb first, then restoring divide msb first
  always_comb begin
    mult   = period - PERIOD_WIDTH'(1);
    sum    = {1'b0, mult & {PERIOD_WIDTH{work[0]}}} + {1'b0, carry}
             + (PERIOD_WIDTH+1)'(x_bit);
    rem_sh = {rem, work[WORK_WIDTH-1]};
    fit    = rem_sh >= {1'b0, period};
    work_next  = work;
    carry_next = carry;
    rem_next   = rem;
    if (ctrl.load) begin
      work_next  = {{PERIOD_WIDTH{1'b0}}, avg};
      carry_next = '0;
      rem_next   = '0;
    end else if (ctrl.mul) begin
      work_next  = {sum[0], work[WORK_WIDTH-1:1]};
      carry_next = sum[PERIOD_WIDTH:1];
    end else if (ctrl.div) begin
      work_next = {work[WORK_WIDTH-2:0], fit};
      if (fit) begin
        rem_next = PERIOD_WIDTH'(rem_sh - {1'b0, period});
      end else begin
        rem_next = rem_sh[PERIOD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    work  <= work_next;
    carry <= carry_next;
    rem   <= rem_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg <= '0;
    end else if (ctrl.store) begin
      avg <= (period == '0) ? '0 : work_next[AVG_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

### design/triple_period_rsi_unit.sv
// triple_period_rsi_unit: RSI over three smoothing periods, one close price per transaction.
// Input channel: close_price with price_valid/price_stall; a transaction is taken only
// while the unit is idle, price_stall is high for the rest of the computation.
// Output channel: rsi_short, rsi_middle, rsi_long, rsi_fresh with rsi_valid/rsi_stall,
// held in an output register, so a new price is taken while a result still waits.
// Six serial lanes (gain and absolute move for each period) run in parallel: a bit-serial
// multiply-add over a PRICE_WIDTH+FRACTION_BITS+8 bit work register, then a bit-serial
// divide by the period. Then a check state and, when all move averages are nonzero, the
// ratio step for each period. Otherwise the ratio step is skipped and the held RSI values
// are given again with rsi_fresh low.
// If the receiver stalls, the result stays in the output register; a finished next
// transaction waits in its last state until the register frees.
// Reset (synchronous) clears the averages, the previous close and the held RSI values,
// and restores periods 6, 12 and 24. Periods are to be written over the APB port while
// idle; the unit itself does not enforce this.
`default_nettype none

module triple_period_rsi_unit #(
  parameter int PRICE_WIDTH   = tprsi_pkg::PRICE_WIDTH_DEFAULT,
  parameter int FRACTION_BITS = tprsi_pkg::FRACTION_BITS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [tprsi_pkg::ADDR_WIDTH-1:0]  paddr,
  input  wire logic [tprsi_pkg::DATA_WIDTH-1:0]  pwdata,
  output logic      [tprsi_pkg::DATA_WIDTH-1:0]  prdata,
  output logic                                   pready,
  input  wire logic                              price_valid,
  output logic                                   price_stall,
  input  wire logic [PRICE_WIDTH-1:0]            close_price,
  output logic                                   rsi_valid,
  input  wire logic                              rsi_stall,
  output logic      [tprsi_pkg::RSI_WIDTH-1:0]   rsi_short,
  output logic      [tprsi_pkg::RSI_WIDTH-1:0]   rsi_middle,
  output logic      [tprsi_pkg::RSI_WIDTH-1:0]   rsi_long,
  output logic                                   rsi_fresh
);
  import tprsi_pkg::*;

  localparam int AVG_WIDTH  = PRICE_WIDTH + FRACTION_BITS;
  localparam int WORK_WIDTH = AVG_WIDTH + PERIOD_WIDTH;
  localparam int CNT_W      = $clog2(WORK_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(WORK_WIDTH - 1);
  localparam logic [CNT_W-1:0] RATIO_LAST = CNT_W'(RSI_WIDTH - 1);

  tprsi_state_t     state, state_next;
  tprsi_lane_ctrl_t lane_ctrl;

  logic [PERIOD_WIDTH-1:0] period [NUM_PERIODS];
  logic [PRICE_WIDTH-1:0]  prev_close;
  logic [PRICE_WIDTH-1:0]  gain_delta, move_delta;
  logic [AVG_WIDTH-1:0]    gain_x, move_x;
  logic [CNT_W-1:0]        cnt;
  logic                    cnt_done;
  logic                    accept;
  logic                    out_free;
  logic                    cfg_write;
  logic                    all_moving;
  logic                    fresh;
  logic [RSI_WIDTH-1:0]    scale_sh;

  logic [AVG_WIDTH-1:0]    gain_avg  [NUM_PERIODS];
  logic [AVG_WIDTH-1:0]    move_avg  [NUM_PERIODS];
  logic [AVG_WIDTH-1:0]    num       [NUM_PERIODS];
  logic [AVG_WIDTH-1:0]    rrem      [NUM_PERIODS];
  logic [AVG_WIDTH-1:0]    rrem_next [NUM_PERIODS];
  logic [AVG_WIDTH+1:0]    racc      [NUM_PERIODS];
  logic [AVG_WIDTH+1:0]    den1      [NUM_PERIODS];
  logic [AVG_WIDTH+1:0]    den2      [NUM_PERIODS];
  logic [RSI_WIDTH-1:0]    rq        [NUM_PERIODS];
  logic [RSI_WIDTH-1:0]    rq_next   [NUM_PERIODS];
  logic [RSI_WIDTH-1:0]    held      [NUM_PERIODS];
  logic [RSI_WIDTH-1:0]    result    [NUM_PERIODS];

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      period[0] <= SHORT_DEFAULT;
      period[1] <= MIDDLE_DEFAULT;
      period[2] <= LONG_DEFAULT;
    end else if (cfg_write) begin
      case (tprsi_reg_t'(paddr[3:2]))
        REG_SHORT:  period[0] <= pwdata[PERIOD_WIDTH-1:0];
        REG_MIDDLE: period[1] <= pwdata[PERIOD_WIDTH-1:0];
        REG_LONG:   period[2] <= pwdata[PERIOD_WIDTH-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (tprsi_reg_t'(paddr[3:2]))
      REG_SHORT:  prdata = DATA_WIDTH'(period[0]);
      REG_MIDDLE: prdata = DATA_WIDTH'(period[1]);
      REG_LONG:   prdata = DATA_WIDTH'(period[2]);
      default:    prdata = '0;
    endcase
  end

  // price change
  always_comb begin
    gain_delta = '0;
    move_delta = '0;
    if (prev_close != '0) begin
      if (close_price >= prev_close) begin
        gain_delta = close_price - prev_close;
        move_delta = gain_delta;
      end else begin
        move_delta = prev_close - close_price;
      end
    end
  end

  // smoothing lanes
  for (genvar i = 0; i < NUM_PERIODS; i++) begin : g_period
    tprsi_smooth_lane #(.AVG_WIDTH(AVG_WIDTH)) u_gain (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (lane_ctrl),
      .period (period[i]),
      .x_bit  (gain_x[0]),
      .avg    (gain_avg[i])
    );
    tprsi_smooth_lane #(.AVG_WIDTH(AVG_WIDTH)) u_move (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (lane_ctrl),
      .period (period[i]),
      .x_bit  (move_x[0]),
      .avg    (move_avg[i])
    );
  end

  // control
  assign accept   = price_valid && !price_stall;
  assign out_free = !rsi_valid || !rsi_stall;

  always_comb begin
    case (state)
      ST_MUL, ST_DIV: cnt_done = (cnt == CNT_LAST);
      ST_RATIO:       cnt_done = (cnt == RATIO_LAST);
      default:        cnt_done = 1'b0;
    endcase
  end

  assign all_moving = (move_avg[0] != '0) && (move_avg[1] != '0) && (move_avg[2] != '0);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (price_valid) state_next = ST_MUL;
      ST_MUL:   if (cnt_done) state_next = ST_DIV;
      ST_DIV:   if (cnt_done) state_next = ST_CHECK;
      ST_CHECK: state_next = all_moving ? ST_RATIO : ST_DONE;
      ST_RATIO: if (cnt_done) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    price_stall     = (state != ST_IDLE);
    lane_ctrl.load  = (state == ST_IDLE) && price_valid;
    lane_ctrl.mul   = (state == ST_MUL);
    lane_ctrl.div   = (state == ST_DIV);
    lane_ctrl.store = (state == ST_DIV) && cnt_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (cnt_done || state == ST_IDLE || state == ST_CHECK || state == ST_DONE) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  // serial change bits feeding the lanes
  always_ff @(posedge clk) begin
    if (accept) begin
      gain_x <= {gain_delta, {FRACTION_BITS{1'b0}}};
      move_x <= {move_delta, {FRACTION_BITS{1'b0}}};
    end else if (state == ST_MUL) begin
      gain_x <= {1'b0, gain_x[AVG_WIDTH-1:1]};
      move_x <= {1'b0, move_x[AVG_WIDTH-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_close <= '0;
    end else if (accept) begin
      prev_close <= close_price;
    end
  end

  // ratio step, one quotient bit per cycle
  always_comb begin
    for (int i = 0; i < NUM_PERIODS; i++) begin
      den1[i] = {2'b00, move_avg[i]};
      den2[i] = {1'b0, move_avg[i], 1'b0};
      racc[i] = {1'b0, rrem[i], 1'b0}
                + {2'b00, scale_sh[RSI_WIDTH-1] ? num[i] : {AVG_WIDTH{1'b0}}};
      if (racc[i] >= den2[i]) begin
        rrem_next[i] = AVG_WIDTH'(racc[i] - den2[i]);
        rq_next[i]   = {rq[i][RSI_WIDTH-2:0], 1'b0} + RSI_WIDTH'(2);
      end else if (racc[i] >= den1[i]) begin
        rrem_next[i] = AVG_WIDTH'(racc[i] - den1[i]);
        rq_next[i]   = {rq[i][RSI_WIDTH-2:0], 1'b0} + RSI_WIDTH'(1);
      end else begin
        rrem_next[i] = racc[i][AVG_WIDTH-1:0];
        rq_next[i]   = {rq[i][RSI_WIDTH-2:0], 1'b0};
      end
      if (!fresh) begin
        result[i] = held[i];
      end else if (rq[i] > RSI_SCALE) begin
        result[i] = RSI_SCALE;
      end else begin
        result[i] = rq[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CHECK) begin
      fresh    <= all_moving;
      scale_sh <= RSI_SCALE;
      for (int i = 0; i < NUM_PERIODS; i++) begin
        num[i]  <= (gain_avg[i] > move_avg[i]) ? move_avg[i] : gain_avg[i];
        rrem[i] <= '0;
        rq[i]   <= '0;
      end
    end else if (state == ST_RATIO) begin
      scale_sh <= {scale_sh[RSI_WIDTH-2:0], 1'b0};
      for (int i = 0; i < NUM_PERIODS; i++) begin
        rrem[i] <= rrem_next[i];
        rq[i]   <= rq_next[i];
      end
    end
  end

  // output register and held values
  always_ff @(posedge clk) begin
    if (rst) begin
      rsi_valid <= 1'b0;
      for (int i = 0; i < NUM_PERIODS; i++) begin
        held[i] <= '0;
      end
    end else if (state == ST_DONE && out_free) begin
      rsi_valid <= 1'b1;
      for (int i = 0; i < NUM_PERIODS; i++) begin
        held[i] <= result[i];
      end
    end else if (!rsi_stall) begin
      rsi_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      rsi_short  <= result[0];
      rsi_middle <= result[1];
      rsi_long   <= result[2];
      rsi_fresh  <= fresh;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_MUL)
    else $error("accepted price did not start the lanes");

  a_ratio_fresh: assert property (@(posedge clk) disable iff (rst)
    state == ST_RATIO |-> fresh)
    else $error("ratio step without nonzero move averages");

  a_ratio_rem: assert property (@(posedge clk) disable iff (rst)
    state == ST_RATIO |-> rrem[0] < move_avg[0] && rrem[1] < move_avg[1]
                          && rrem[2] < move_avg[2])
    else $error("ratio remainder not below divisor");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    rsi_valid |-> rsi_short == held[0] && rsi_middle == held[1] && rsi_long == held[2])
    else $error("output differs from held values");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    rsi_valid |-> rsi_short <= RSI_SCALE && rsi_middle <= RSI_SCALE
                  && rsi_long <= RSI_SCALE)
    else $error("rsi out of range");

endmodule

`default_nettype wire
